// ----- src/gsms_pkg.sv -----
package gsms_pkg;

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic REG_HUMIDITY = 1'b0;
	localparam logic REG_BUS_ADDR = 1'b1;
	localparam logic [6:0] BUS_ADDR_RESET = 7'd88;

	// Sequence steps: the request that is outstanding
	localparam logic [2:0] STEP_FEAT_WR = 3'd0;
	localparam logic [2:0] STEP_FEAT_RD = 3'd1;
	localparam logic [2:0] STEP_INIT_WR = 3'd2;
	localparam logic [2:0] STEP_HUM_WR = 3'd3;
	localparam logic [2:0] STEP_MEAS_WR = 3'd4;
	localparam logic [2:0] STEP_MEAS_RD = 3'd5;

	// Request kinds
	localparam logic [1:0] KIND_WR_CMD = 2'd0;
	localparam logic [1:0] KIND_WR_WORD = 2'd1;
	localparam logic [1:0] KIND_RD3 = 2'd2;
	localparam logic [1:0] KIND_RD6 = 2'd3;

	// Sensor commands
	localparam logic [15:0] CMD_FEATURE = 16'h202F;
	localparam logic [15:0] CMD_INIT = 16'h2003;
	localparam logic [15:0] CMD_HUMIDITY = 16'h2061;
	localparam logic [15:0] CMD_MEASURE = 16'h2008;
	localparam logic [15:0] CMD_NONE = 16'h0000;

	// Waits in milliseconds
	localparam logic [9:0] WAIT_NORMAL = 10'd30;
	localparam logic [9:0] WAIT_RETRY = 10'd500;
	localparam logic [9:0] WAIT_PERIODIC = 10'd1000;

	// CRC-8 and feature-set reply
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] FEAT_ID_HI = 8'h00;
	localparam logic [7:0] FEAT_ID_LO = 8'h20;

	typedef struct packed {
		logic [1:0]  request_kind;
		logic [15:0] command_word;
		logic [15:0] payload_word;
		logic [7:0]  payload_crc;
		logic [9:0]  wait_ms;
		logic        wait_from_humidity;
		logic [15:0] co2eq_ppm;
		logic [15:0] tvoc_ppb;
		logic        reading_valid;
		logic        error_seen;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		int i;
		c = crc_in ^ data;
		for (i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_word(input logic [15:0] w);
		return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

endpackage

// ----- src/gsms_apb_regs.sv -----
module gsms_apb_regs import gsms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [15:0]       humidity_word
);

	logic [15:0] humidity_q;
	logic [6:0]  bus_addr_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			humidity_q <= '0;
			bus_addr_q <= BUS_ADDR_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_HUMIDITY: humidity_q <= pwdata[15:0];
				REG_BUS_ADDR: bus_addr_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HUMIDITY: prdata = {{(DATA_W-16){1'b0}}, humidity_q};
			REG_BUS_ADDR: prdata = {{(DATA_W-7){1'b0}}, bus_addr_q};
			default:      prdata = '0;
		endcase
	end

	assign humidity_word = humidity_q;

endmodule

// ----- src/gsms_seq_core.sv -----
module gsms_seq_core import gsms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        transfer_ok,
	input  logic [47:0] read_bytes,
	input  logic [15:0] humidity_word,
	output result_t     result
);

	logic [2:0]  step_q;
	logic [15:0] co2_q;
	logic [15:0] voc_q;
	logic        valid_q;
	logic        err_q;

	logic [2:0]  step_d;
	logic [15:0] co2_d;
	logic [15:0] voc_d;
	logic        valid_d;
	logic        err_d;
	logic        ok;
	logic        word0_bad;
	logic        word1_bad;
	logic        feat_bad;
	logic [9:0]  wait_d;
	logic        from_hum_d;

	// A word and its CRC agree when the CRC of the word equals the CRC byte
	assign word0_bad = crc8_word(read_bytes[47:32]) != read_bytes[31:24];
	assign word1_bad = crc8_word(read_bytes[23:8]) != read_bytes[7:0];
	assign feat_bad = word0_bad || (read_bytes[47:40] != FEAT_ID_HI)
		|| (read_bytes[39:32] != FEAT_ID_LO);

	always_comb begin
		ok = transfer_ok;
		step_d = STEP_FEAT_WR;
		co2_d = co2_q;
		voc_d = voc_q;
		valid_d = valid_q;
		err_d = err_q;
		wait_d = WAIT_NORMAL;
		from_hum_d = 1'b0;
		unique case (step_q)
			STEP_FEAT_WR: step_d = STEP_FEAT_RD;
			STEP_FEAT_RD: begin
				if (feat_bad) begin
					ok = 1'b0;
				end
				step_d = STEP_INIT_WR;
			end
			STEP_INIT_WR: step_d = STEP_HUM_WR;
			STEP_HUM_WR:  step_d = STEP_MEAS_WR;
			STEP_MEAS_WR: step_d = STEP_MEAS_RD;
			STEP_MEAS_RD: begin
				if (word0_bad || word1_bad) begin
					ok = 1'b0;
				end
				if (ok) begin
					co2_d = read_bytes[47:32];
					voc_d = read_bytes[23:8];
					valid_d = 1'b1;
					from_hum_d = 1'b1;
					wait_d = WAIT_PERIODIC;
				end
				step_d = STEP_HUM_WR;
			end
			default: ok = 1'b0;
		endcase
		// Failure: flag it, drop validity, restart from the feature-set write
		if (!ok) begin
			err_d = 1'b1;
			valid_d = 1'b0;
			step_d = STEP_FEAT_WR;
			wait_d = WAIT_RETRY;
			from_hum_d = 1'b0;
		end
	end

	always_comb begin
		result.payload_word = '0;
		result.payload_crc = '0;
		unique case (step_d)
			STEP_FEAT_WR: begin
				result.request_kind = KIND_WR_CMD;
				result.command_word = CMD_FEATURE;
			end
			STEP_FEAT_RD: begin
				result.request_kind = KIND_RD3;
				result.command_word = CMD_NONE;
			end
			STEP_INIT_WR: begin
				result.request_kind = KIND_WR_CMD;
				result.command_word = CMD_INIT;
			end
			STEP_HUM_WR: begin
				result.request_kind = KIND_WR_WORD;
				result.command_word = CMD_HUMIDITY;
				result.payload_word = humidity_word;
				result.payload_crc = crc8_word(humidity_word);
			end
			STEP_MEAS_WR: begin
				result.request_kind = KIND_WR_CMD;
				result.command_word = CMD_MEASURE;
			end
			default: begin
				result.request_kind = KIND_RD6;
				result.command_word = CMD_NONE;
			end
		endcase
		result.wait_ms = wait_d;
		result.wait_from_humidity = from_hum_d;
		result.co2eq_ppm = co2_d;
		result.tvoc_ppb = voc_d;
		result.reading_valid = valid_d;
		result.error_seen = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FEAT_WR;
			co2_q <= '0;
			voc_q <= '0;
			valid_q <= 1'b0;
			err_q <= 1'b0;
		end else if (advance) begin
			step_q <= step_d;
			co2_q <= co2_d;
			voc_q <= voc_d;
			valid_q <= valid_d;
			err_q <= err_d;
		end
	end

endmodule

// ----- src/gas_sensor_measure_sequencer_unit.sv -----
// Measurement sequencer for an air-quality sensor on a two-wire bus.
// Input channel (in_valid/in_ready): one transaction reports the outcome of
// the bus transfer last requested, transfer_ok plus up to six read bytes.
// Output channel (out_valid/out_ready): one transaction per input, giving the
// next transfer request (kind, command, humidity word and its CRC, wait) and
// the latest CO2eq/TVOC readings with the valid and sticky error flags.
// Configuration: APB-style port, humidity word at 0x0, bus address at 0x4;
// pready is always high. Write only while the block is idle.
// Pipeline: an accepted transaction passes through two register stages, input
// and result, before it is offered on the output. Throughput is one
// transaction per cycle while out_ready stays high, set by the step logic.
// Reset: the sequence restarts at the feature-set write, readings and flags
// clear, humidity word clears and the bus address returns to 88.
// Receiver stall: the result register holds its transaction; the input stage
// keeps accepting until it too is full, then in_ready drops.
module gas_sensor_measure_sequencer_unit import gsms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              transfer_ok,
	input  logic [47:0]       read_bytes,
	// Output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        request_kind,
	output logic [15:0]       command_word,
	output logic [15:0]       payload_word,
	output logic [7:0]        payload_crc,
	output logic [9:0]        wait_ms,
	output logic              wait_from_humidity,
	output logic [15:0]       co2eq_ppm,
	output logic [15:0]       tvoc_ppb,
	output logic              reading_valid,
	output logic              error_seen
);

	logic [15:0] humidity_word;

	// Input stage
	logic        valid_s1;
	logic        ok_s1;
	logic [47:0] rd_s1;

	// Result stage
	logic        valid_s2;
	result_t     result_s2;

	result_t     step_result;
	logic        advance;
	logic        s2_free;

	gsms_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.humidity_word (humidity_word)
	);

	// The result register takes a new transaction when empty or being drained
	assign s2_free = !valid_s2 || out_ready;
	assign advance = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	gsms_seq_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.transfer_ok   (ok_s1),
		.read_bytes    (rd_s1),
		.humidity_word (humidity_word),
		.result        (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload when the stage is not taking a new transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ok_s1 <= transfer_ok;
			rd_s1 <= read_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign out_valid = valid_s2;
	assign request_kind = result_s2.request_kind;
	assign command_word = result_s2.command_word;
	assign payload_word = result_s2.payload_word;
	assign payload_crc = result_s2.payload_crc;
	assign wait_ms = result_s2.wait_ms;
	assign wait_from_humidity = result_s2.wait_from_humidity;
	assign co2eq_ppm = result_s2.co2eq_ppm;
	assign tvoc_ppb = result_s2.tvoc_ppb;
	assign reading_valid = result_s2.reading_valid;
	assign error_seen = result_s2.error_seen;

	// A transaction leaving the input stage always lands in the result stage
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced transaction did not reach the result stage");

	// The error flag is sticky across results
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.error_seen) |=> result_s2.error_seen)
		else $error("sticky error flag cleared");

	// The periodic wait belongs only to the humidity write
	a_periodic_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.wait_from_humidity) |->
		(result_s2.wait_ms == WAIT_PERIODIC && result_s2.request_kind == KIND_WR_WORD))
		else $error("periodic wait on a request other than the humidity write");

	// A retry restarts at the feature-set write with readings invalid
	a_retry_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.wait_ms == WAIT_RETRY) |->
		(result_s2.command_word == CMD_FEATURE && !result_s2.reading_valid
		&& result_s2.error_seen))
		else $error("retry without restart or error flag");

endmodule

// ----- tb/gas_sensor_measure_sequencer_unit_test.sv -----
`timescale 1ns / 100ps

// Checks the measurement sequencer end to end. Bus outcomes go in as
// transactions, next-request results come out, and each result is compared
// with an in-bench model of the sensor sequence. The model covers the CRC-8
// word checks, the feature-set reply, the latched readings and the sticky
// error. The sequence state carries across configuration changes and is
// reset only at the start of the run.
module gas_sensor_measure_sequencer_unit_test;
	import gsms_pkg::*;

	// Register byte addresses: index times four
	localparam logic [ADDR_W-1:0] HUMIDITY_ADDR = {REG_HUMIDITY, 2'b00};
	localparam logic [ADDR_W-1:0] BUS_ADDR_ADDR = {REG_BUS_ADDR, 2'b00};

	// Cycles without any accepted transaction before the run is abandoned
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned BURST_LEN = 380;

	typedef struct {
		logic        ok;
		logic [47:0] rd;
		logic        typed;
		result_t     want;
	} script_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              transfer_ok = 1'b0;
	logic [47:0]       read_bytes = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        request_kind;
	logic [15:0]       command_word;
	logic [15:0]       payload_word;
	logic [7:0]        payload_crc;
	logic [9:0]        wait_ms;
	logic              wait_from_humidity;
	logic [15:0]       co2eq_ppm;
	logic [15:0]       tvoc_ppb;
	logic              reading_valid;
	logic              error_seen;

	// Model state: outstanding step, latched readings, flags, humidity register
	logic [2:0]  seq_step = STEP_FEAT_WR;
	logic [15:0] co2_latch = '0;
	logic [15:0] voc_latch = '0;
	logic        readings_ok = 1'b0;
	logic        error_latch = 1'b0;
	logic [15:0] humidity_reg = '0;

	result_t     pending_requests[$];
	script_row_t script[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned outcomes_sent = 0;
	int unsigned outcomes_rejected = 0;
	int unsigned readings_latched = 0;
	int unsigned requests_checked = 0;

	gas_sensor_measure_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.transfer_ok(transfer_ok),
		.read_bytes(read_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.request_kind(request_kind),
		.command_word(command_word),
		.payload_word(payload_word),
		.payload_crc(payload_crc),
		.wait_ms(wait_ms),
		.wait_from_humidity(wait_from_humidity),
		.co2eq_ppm(co2eq_ppm),
		.tvoc_ppb(tvoc_ppb),
		.reading_valid(reading_valid),
		.error_seen(error_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bit-serial CRC-8, polynomial 0x31, seed 0xFF, MSB first over a 16-bit word
	function automatic logic [7:0] sensor_crc(input logic [15:0] w);
		logic [7:0] c;
		logic       fb;
		c = 8'hFF;
		for (int i = 15; i >= 0; i--) begin
			fb = c[7] ^ w[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return c;
	endfunction

	// Word followed by its CRC, as the sensor sends it
	function automatic logic [23:0] sealed(input logic [15:0] w);
		return {w, sensor_crc(w)};
	endfunction

	function automatic logic word_intact(input logic [23:0] wc);
		return sensor_crc(wc[23:8]) == wc[7:0];
	endfunction

	function automatic result_t req(input logic [1:0] kind, input logic [15:0] cmd,
			input logic [15:0] pw, input logic [7:0] pc, input logic [9:0] wt,
			input logic fh, input logic [15:0] co2, input logic [15:0] voc,
			input logic v, input logic e);
		result_t r;
		r.request_kind = kind;
		r.command_word = cmd;
		r.payload_word = pw;
		r.payload_crc = pc;
		r.wait_ms = wt;
		r.wait_from_humidity = fh;
		r.co2eq_ppm = co2;
		r.tvoc_ppb = voc;
		r.reading_valid = v;
		r.error_seen = e;
		return r;
	endfunction

	// Advance the sequence by one bus outcome and return the next request
	function automatic result_t advance_sequencer(input logic ok, input logic [47:0] rd);
		result_t    r;
		logic       pass;
		logic [2:0] nxt;
		logic [9:0] wt;
		logic       fh;
		pass = ok;
		wt = WAIT_NORMAL;
		fh = 1'b0;
		case (seq_step)
			STEP_FEAT_WR: nxt = STEP_FEAT_RD;
			STEP_FEAT_RD: begin
				if (rd[47:40] != FEAT_ID_HI || rd[39:32] != FEAT_ID_LO || !word_intact(rd[47:24]))
					pass = 1'b0;
				nxt = STEP_INIT_WR;
			end
			STEP_INIT_WR: nxt = STEP_HUM_WR;
			STEP_HUM_WR: nxt = STEP_MEAS_WR;
			STEP_MEAS_WR: nxt = STEP_MEAS_RD;
			STEP_MEAS_RD: begin
				if (!word_intact(rd[47:24]) || !word_intact(rd[23:0]))
					pass = 1'b0;
				if (pass) begin
					co2_latch = rd[47:32];
					voc_latch = rd[23:8];
					readings_ok = 1'b1;
					fh = 1'b1;
					wt = WAIT_PERIODIC;
					readings_latched++;
				end
				nxt = STEP_HUM_WR;
			end
			// Unused step codes behave as a failure
			default: begin
				pass = 1'b0;
				nxt = STEP_FEAT_WR;
			end
		endcase
		if (!pass) begin
			error_latch = 1'b1;
			readings_ok = 1'b0;
			nxt = STEP_FEAT_WR;
			wt = WAIT_RETRY;
			fh = 1'b0;
			outcomes_rejected++;
		end
		seq_step = nxt;
		r = req(KIND_RD6, CMD_NONE, 16'h0000, 8'h00, wt, fh, co2_latch, voc_latch,
			readings_ok, error_latch);
		case (nxt)
			STEP_FEAT_WR: begin
				r.request_kind = KIND_WR_CMD;
				r.command_word = CMD_FEATURE;
			end
			STEP_FEAT_RD: r.request_kind = KIND_RD3;
			STEP_INIT_WR: begin
				r.request_kind = KIND_WR_CMD;
				r.command_word = CMD_INIT;
			end
			STEP_HUM_WR: begin
				r.request_kind = KIND_WR_WORD;
				r.command_word = CMD_HUMIDITY;
				r.payload_word = humidity_reg;
				r.payload_crc = sensor_crc(humidity_reg);
			end
			STEP_MEAS_WR: begin
				r.request_kind = KIND_WR_CMD;
				r.command_word = CMD_MEASURE;
			end
			default: r.request_kind = KIND_RD6;
		endcase
		return r;
	endfunction

	task automatic match_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// APB write: setup cycle, then access; the register takes the data at the access edge
	task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_read_check(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] want,
			input string name);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("%s: expected %0h, got %0h", name, want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_sensor(input logic [15:0] hum, input logic [6:0] addr);
		reg_write(HUMIDITY_ADDR, {16'd0, hum});
		reg_write(BUS_ADDR_ADDR, {25'd0, addr});
		humidity_reg = hum;
		reg_read_check(HUMIDITY_ADDR, {16'd0, hum}, "humidity_word");
		reg_read_check(BUS_ADDR_ADDR, {25'd0, addr}, "bus_address");
	endtask

	// Offer one outcome, hold it until taken, then record what the block should ask next.
	// A typed row supplies its own expectation; the model still advances.
	task automatic push_outcome(input logic ok, input logic [47:0] rd, input logic typed,
			input result_t want);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		transfer_ok <= ok;
		read_bytes <= rd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = advance_sequencer(ok, rd);
		pending_requests.push_back(typed ? want : predicted);
		outcomes_sent++;
	endtask

	// Drop valid and wait until every outstanding request has been taken
	task automatic settle(input int unsigned linger);
		in_valid <= 1'b0;
		while (pending_requests.size() != 0)
			@(posedge clk);
		repeat (linger) @(posedge clk);
	endtask

	// Mostly well-formed replies for the step in flight; the rest carry bus
	// failures or a single flipped bit, which the CRC check must catch
	task automatic random_burst(input int unsigned count);
		logic        ok;
		logic [47:0] rd;
		int unsigned roll;
		int unsigned flip_pos;
		for (int unsigned n = 0; n < count; n++) begin
			if (n == count / 2)
				settle(0);
			roll = $urandom_range(99);
			ok = (roll >= 5);
			rd = {16'($urandom), 32'($urandom)};
			case (seq_step)
				STEP_FEAT_RD: begin
					rd[47:24] = sealed({FEAT_ID_HI, FEAT_ID_LO});
					if (roll >= 5 && roll < 15) begin
						flip_pos = 24 + $urandom_range(23);
						rd[flip_pos] = ~rd[flip_pos];
					end
				end
				STEP_MEAS_RD: begin
					rd = {sealed(16'($urandom)), sealed(16'($urandom))};
					if (roll >= 5 && roll < 13) begin
						flip_pos = $urandom_range(47);
						rd[flip_pos] = ~rd[flip_pos];
					end
				end
				default: ;
			endcase
			push_outcome(ok, rd, 1'b0, '0);
		end
	endtask

	// Receiver: take results, stalling at the current rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each taken result with the oldest outstanding expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_requests.size() == 0) begin
				$error("request transaction with nothing outstanding: kind %0h command %0h",
					request_kind, command_word);
				mismatches++;
			end else begin
				want = pending_requests.pop_front();
				match_field("request_kind", want.request_kind, request_kind);
				match_field("command_word", want.command_word, command_word);
				match_field("payload_word", want.payload_word, payload_word);
				match_field("payload_crc", want.payload_crc, payload_crc);
				match_field("wait_ms", want.wait_ms, wait_ms);
				match_field("wait_from_humidity", want.wait_from_humidity, wait_from_humidity);
				match_field("co2eq_ppm", want.co2eq_ppm, co2eq_ppm);
				match_field("tvoc_ppb", want.tvoc_ppb, tvoc_ppb);
				match_field("reading_valid", want.reading_valid, reading_valid);
				match_field("error_seen", want.error_seen, error_seen);
				requests_checked++;
			end
		end
	end

	// Abandon the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("** gas_sensor_measure_sequencer_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers must come out of reset at their documented values
		reg_read_check(HUMIDITY_ADDR, '0, "humidity_word");
		reg_read_check(BUS_ADDR_ADDR, {25'd0, BUS_ADDR_RESET}, "bus_address");
		program_sensor(16'hBEEF, 7'd0);

		// Directed walk from reset. Typed rows spell out the request; 0xBEEF seals to 0x92.
		script.push_back('{1'b1, 48'h0, 1'b1,
			req(KIND_RD3, CMD_NONE, 16'h0, 8'h0, WAIT_NORMAL, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0)});
		script.push_back('{1'b1, {sealed({FEAT_ID_HI, FEAT_ID_LO}), 24'hFFFFFF}, 1'b1,
			req(KIND_WR_CMD, CMD_INIT, 16'h0, 8'h0, WAIT_NORMAL, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0)});
		script.push_back('{1'b1, 48'hFFFF_FFFF_FFFF, 1'b1,
			req(KIND_WR_WORD, CMD_HUMIDITY, 16'hBEEF, 8'h92, WAIT_NORMAL, 1'b0,
				16'h0, 16'h0, 1'b0, 1'b0)});
		script.push_back('{1'b1, 48'h0, 1'b1,
			req(KIND_WR_CMD, CMD_MEASURE, 16'h0, 8'h0, WAIT_NORMAL, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0)});
		script.push_back('{1'b1, 48'hA5A5_5A5A_0F0F, 1'b1,
			req(KIND_RD6, CMD_NONE, 16'h0, 8'h0, WAIT_NORMAL, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0)});
		// Good measurement at the extremes: periodic humidity write, counted from the last one
		script.push_back('{1'b1, {sealed(16'hFFFF), sealed(16'h0000)}, 1'b1,
			req(KIND_WR_WORD, CMD_HUMIDITY, 16'hBEEF, 8'h92, WAIT_PERIODIC, 1'b1,
				16'hFFFF, 16'h0000, 1'b1, 1'b0)});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		// Corrupt CRC on the second word: restart after the retry wait, readings kept
		script.push_back('{1'b1, {sealed(16'h1234), sealed(16'h5678) ^ 24'h000001}, 1'b1,
			req(KIND_WR_CMD, CMD_FEATURE, 16'h0, 8'h0, WAIT_RETRY, 1'b0,
				16'hFFFF, 16'h0000, 1'b0, 1'b1)});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		// Feature reply with the wrong identity but a sound CRC
		script.push_back('{1'b1, {sealed(16'h0021), 24'h0}, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		// Right identity, broken CRC
		script.push_back('{1'b1, {FEAT_ID_HI, FEAT_ID_LO, ~sensor_crc({FEAT_ID_HI, FEAT_ID_LO}),
			24'h0}, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		// Sound reply, but the bus reports the transfer failed
		script.push_back('{1'b0, {sealed({FEAT_ID_HI, FEAT_ID_LO}), 24'h0}, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		script.push_back('{1'b1, {sealed({FEAT_ID_HI, FEAT_ID_LO}), 24'h0}, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});
		// Corrupt CRC on the first word
		script.push_back('{1'b1, {sealed(16'h0000) ^ 24'h000001, sealed(16'hFFFF)}, 1'b0, '0});
		// Failed write while already restarting
		script.push_back('{1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0});
		script.push_back('{1'b1, 48'h0, 1'b0, '0});

		send_idle_pct = 15;
		recv_idle_pct = 51;
		foreach (script[i])
			push_outcome(script[i].ok, script[i].rd, script[i].typed, script[i].want);
		settle(4);

		// Random phases, each under a fresh register setting
		program_sensor(16'h0000, 7'd127);
		random_burst(BURST_LEN);
		settle(4);

		send_idle_pct = 51;
		recv_idle_pct = 15;
		program_sensor(16'hFFFF, 7'($urandom_range(127)));
		random_burst(BURST_LEN);
		settle(4);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_sensor(16'($urandom_range(16'hFFFF)), 7'($urandom_range(127)));
		random_burst(BURST_LEN);
		settle(12);

		$display("Sent %0d bus outcomes, %0d rejected by the sequencer, %0d readings latched;",
			outcomes_sent, outcomes_rejected, readings_latched);
		$display("checked %0d requests over four register settings and three idling mixes.",
			requests_checked);
		if (mismatches == 0)
			$display("** gas_sensor_measure_sequencer_unit: PASSED **");
		else
			$display("** gas_sensor_measure_sequencer_unit: FAILED **");
		$finish;
	end

endmodule
